FILE: rtl/radix_digit_converter_defines.svh
// assertion macros for the radix digit converter
// no dependencies; taken in by `include where assertions are written
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// implication checked at every rising edge outside reset
`define RDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("radix digit converter: implication violated");

// invariant checked at every rising edge outside reset
`define RDC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("radix digit converter: invariant violated");

`endif

FILE: rtl/rdc_pkg.sv
// shared types, character codes and helpers of the radix digit converter
// no dependencies
package rdc_pkg;

	// bits of the quotient consumed per division cycle
	localparam int DIV_BITS = 8;

	localparam logic [4:0] RADIX_MIN = 5'd2;
	localparam logic [4:0] RADIX_MAX = 5'd16;

	localparam logic [7:0] CH_MINUS      = 8'h2d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_ALPHA_BASE = 8'h57; // 'a' minus ten

	typedef struct packed {
		logic [31:0] value;
		logic [4:0]  radix;
		logic        signed_mode;
		logic [5:0]  min_width;
	} item_t;

	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} text_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic emit_init;
		logic rd;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic div_done;
		logic pos_zero;
		logic out_free;
	} status_t;

	// ascii of one digit, lowercase letters above nine
	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return (d < 4'd10) ? (CH_ZERO + {4'b0000, d}) : (CH_ALPHA_BASE + {4'b0000, d});
	endfunction

endpackage

FILE: rtl/radix_digit_converter.sv
// radix digit converter, top level: one value in, its ascii text out one character per transfer
// all digits are produced first by the 8-bit-per-cycle remainder unit, then read back
// from the registered digit ram, one read per character; item_stall holds off a new item
// until the last character of the current one has been loaded
// reset: arst_n clears the controller, counters and output valid; the digit ram needs no clearing
// depends on rdc_pkg, rdc_ctrl and rdc_datapath
module radix_digit_converter #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_CHARS  = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	output logic           item_stall,
	input  rdc_pkg::item_t item,
	output logic           text_valid,
	input  logic           text_stall,
	output rdc_pkg::text_t text
);

	rdc_pkg::cmd_t    cmd;
	rdc_pkg::status_t status;

	// sequencer
	rdc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// conversion datapath
	rdc_datapath #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_CHARS  (MAX_CHARS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cmd        (cmd),
		.status     (status),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text       (text)
	);

endmodule

FILE: rtl/rdc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module rdc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 32
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rdc_datapath.sv
// datapath: operand capture, digit-serial remainder unit, digit ram, text output register
// depends on rdc_pkg, rdc_ram and radix_digit_converter_defines.svh
`include "radix_digit_converter_defines.svh"

module rdc_datapath #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_CHARS  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  rdc_pkg::item_t   item,
	input  rdc_pkg::cmd_t    cmd,
	output rdc_pkg::status_t status,
	output logic             text_valid,
	input  logic             text_stall,
	output rdc_pkg::text_t   text
);

	localparam int DB     = rdc_pkg::DIV_BITS;
	localparam int QBITS  = ((VALUE_BITS + DB - 1) / DB) * DB;
	localparam int NSTEPS = QBITS / DB;
	localparam int STEP_W = (NSTEPS > 1) ? $clog2(NSTEPS) : 1;
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);
	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int TOT_W  = $clog2(VALUE_BITS + MAX_CHARS + 2);
	localparam int WIDE   = (VALUE_BITS > 32) ? VALUE_BITS : 32;

	logic [QBITS-1:0]  q_q;
	logic [4:0]        r_q;
	logic [4:0]        rad_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  ndig_q;
	logic              neg_q;
	logic [7:0]        pad_q;
	logic [TOT_W-1:0]  width_q;
	logic [TOT_W-1:0]  p_q;
	logic              out_valid_q;
	rdc_pkg::text_t    out_q;

	// operand preparation
	logic [WIDE-1:0]       ext;
	logic [VALUE_BITS-1:0] v;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic [4:0]            rad;
	logic [6:0]            wcl;

	assign ext = WIDE'(item.value);
	assign v   = ext[VALUE_BITS-1:0];
	assign neg = item.signed_mode & v[VALUE_BITS-1];
	assign mag = neg ? (~v + 1'b1) : v;

	always_comb begin
		if (item.radix < rdc_pkg::RADIX_MIN) begin
			rad = rdc_pkg::RADIX_MIN;
		end else if (item.radix > rdc_pkg::RADIX_MAX) begin
			rad = rdc_pkg::RADIX_MAX;
		end else begin
			rad = item.radix;
		end
	end

	assign wcl = ({1'b0, item.min_width} > 7'(MAX_CHARS)) ? 7'(MAX_CHARS)
		: {1'b0, item.min_width};

	// restoring division, DB quotient bits per cycle, msb first
	logic [DB-1:0]    top_bits;
	logic [DB-1:0]    qb;
	logic [4:0]       rr;
	logic [QBITS-1:0] q_next;
	logic             step_last;

	assign top_bits = q_q[QBITS-1 -: DB];

	always_comb begin
		rr = r_q;
		qb = '0;
		for (int i = 0; i < DB; i++) begin
			rr = {rr[3:0], top_bits[DB-1-i]};
			qb[DB-1-i] = (rr >= rad_q);
			if (rr >= rad_q) begin
				rr = rr - rad_q;
			end
		end
	end

	assign q_next    = (q_q << DB) | QBITS'(qb);
	assign step_last = (step_q == STEP_W'(NSTEPS - 1));

	// digit store, least significant digit at address zero
	logic              ram_we;
	logic              ram_re;
	logic [3:0]        ram_rdata;
	logic [TOT_W-1:0]  ndig_ext;

	assign ram_we   = cmd.div_step & step_last;
	assign ndig_ext = TOT_W'(ndig_q);
	assign ram_re   = cmd.rd & (p_q < ndig_ext);

	rdc_ram #(
		.WIDTH (4),
		.DEPTH (VALUE_BITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ndig_q[ADDR_W-1:0]),
		.wdata (rr[3:0]),
		.re    (ram_re),
		.raddr (p_q[ADDR_W-1:0]),
		.rdata (ram_rdata)
	);

	// text length: padded width or sign plus digits, keeping the rightmost MAX_CHARS
	logic [TOT_W-1:0] body_len;
	logic [TOT_W-1:0] total_len;
	logic [TOT_W-1:0] emit_len;

	assign body_len  = ndig_ext + TOT_W'(neg_q);
	assign total_len = (width_q > body_len) ? width_q : body_len;
	assign emit_len  = (total_len > TOT_W'(MAX_CHARS)) ? TOT_W'(MAX_CHARS) : total_len;

	// character at position p counted from the right
	logic [7:0] chr;

	always_comb begin
		if (p_q < ndig_ext) begin
			chr = rdc_pkg::digit_char(ram_rdata);
		end else if ((p_q == ndig_ext) && neg_q) begin
			chr = rdc_pkg::CH_MINUS;
		end else begin
			chr = pad_q;
		end
	end

	// operand and division registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			q_q     <= QBITS'(mag);
			rad_q   <= rad;
			neg_q   <= neg;
			pad_q   <= item.signed_mode ? rdc_pkg::CH_SPACE : rdc_pkg::CH_ZERO;
			width_q <= TOT_W'(wcl);
		end else if (cmd.div_step) begin
			q_q <= q_next;
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			step_q <= '0;
			ndig_q <= '0;
			p_q    <= '0;
		end else begin
			if (cmd.load) begin
				r_q    <= '0;
				step_q <= '0;
				ndig_q <= '0;
			end else if (cmd.div_step) begin
				if (step_last) begin
					r_q    <= '0;
					step_q <= '0;
					ndig_q <= ndig_q + 1'b1;
				end else begin
					r_q    <= rr;
					step_q <= step_q + 1'b1;
				end
			end
			if (cmd.emit_init) begin
				p_q <= emit_len - 1'b1;
			end else if (cmd.load_out) begin
				p_q <= p_q - 1'b1;
			end
		end
	end

	// text output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!text_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.character <= chr;
			out_q.last      <= (p_q == '0);
		end
	end

	assign text_valid      = out_valid_q;
	assign text            = out_q;
	assign status.div_done = step_last & (q_next == '0);
	assign status.pos_zero = (p_q == '0);
	assign status.out_free = ~out_valid_q | ~text_stall;

	// checks
	`RDC_ASSERT_IMPL(a_digit_in_range, clk, arst_n, ram_we, ndig_q < VALUE_BITS)
	`RDC_ASSERT_ALWAYS(a_digit_count, clk, arst_n, ndig_q <= VALUE_BITS)
	`RDC_ASSERT_IMPL(a_rem_below_radix, clk, arst_n, cmd.div_step, r_q < rad_q)
	`RDC_ASSERT_IMPL(a_pos_in_window, clk, arst_n, cmd.load_out, p_q < MAX_CHARS)
	`RDC_ASSERT_IMPL(a_load_after_last, clk, arst_n, cmd.load, !(out_valid_q && !out_q.last))

endmodule

FILE: rtl/rdc_ctrl.sv
// controller: sequences capture, division, length setup and character emission
// depends on rdc_pkg
module rdc_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  rdc_pkg::status_t status,
	output rdc_pkg::cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INIT,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;

	assign item_stall = (state_q != ST_IDLE);

	// commands decoded from state and status
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load      = item_valid;
			ST_DIV:  cmd.div_step  = 1'b1;
			ST_INIT: cmd.emit_init = 1'b1;
			ST_READ: cmd.rd        = 1'b1;
			ST_LOAD: cmd.load_out  = status.out_free;
			default: cmd = '0;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (status.div_done) begin
						state_q <= ST_INIT;
					end
				end
				ST_INIT: state_q <= ST_READ;
				ST_READ: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (status.out_free) begin
						state_q <= status.pos_zero ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
